[rtl/vln_pkg.sv]
// ----------------------------------------------------------------------------
// vln_pkg
// shared widths and defaults for the vector length / normalize / distance block
// ----------------------------------------------------------------------------
package vln_pkg;

  localparam int unsigned VecW          = 32;
  localparam int unsigned DiffW         = VecW + 1;
  localparam int unsigned MagW          = VecW + 1;
  localparam int unsigned SqW           = 2 * MagW;
  localparam int unsigned SumW          = SqW + 1;
  localparam int unsigned SqrtSteps     = MagW;
  localparam int unsigned UnitFracBitsD = 30;

endpackage

[rtl/vln_div.sv]
// ----------------------------------------------------------------------------
// vln_div
// pipelined fractional divider lane: floor(mag * 2^UNIT_FRAC_BITS / len)
// one quotient bit per register stage, needs mag <= len
// ----------------------------------------------------------------------------
module vln_div
  import vln_pkg::*;
#(
  parameter int unsigned UNIT_FRAC_BITS = UnitFracBitsD
) (
  input  logic                     clk_i,
  input  logic [VecW-1:0]          mag_i,
  input  logic [MagW-1:0]          len_i,
  output logic [UNIT_FRAC_BITS:0]  quo_o
);

  localparam int unsigned Steps = UNIT_FRAC_BITS + 1;
  localparam int unsigned RemW  = MagW + 1;

  logic [RemW-1:0]           rem_q [Steps+1];
  logic [MagW-1:0]           len_q [Steps+1];
  logic [UNIT_FRAC_BITS:0]   quo_q [Steps+1];

  assign rem_q[0] = RemW'(mag_i);
  assign len_q[0] = len_i;
  assign quo_q[0] = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic            take;
    logic [RemW-1:0] rem_d;
    assign take  = rem_q[k] >= RemW'(len_q[k]);
    assign rem_d = take ? rem_q[k] - RemW'(len_q[k]) : rem_q[k];
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= {rem_d[RemW-2:0], 1'b0};
      len_q[k+1] <= len_q[k];
      quo_q[k+1] <= {quo_q[k][UNIT_FRAC_BITS-1:0], take};
    end
  end

  assign quo_o = quo_q[Steps];

endmodule

[rtl/vector3_length_normalize_distance.sv]
// ----------------------------------------------------------------------------
// vector3_length_normalize_distance
// length and unit vector of a, or distance a to b, in fixed point
// ----------------------------------------------------------------------------
// usage:
//   a word is taken at a rising edge with start_i high and busy_o low.
//   busy_o stays low: the pipeline takes one word every cycle.
//   func_i 0 gives |a| and a/|a| in Q1.30, func_i 1 gives |a-b|.
//   the result shows on the result ports for one cycle with done_o high.
//   the bit-serial root (33 stages) and the divider lanes (UNIT_FRAC_BITS + 1
//   stages) each resolve one bit per register stage.
//   throughput is one word per cycle, results in order.
//   reset clears every valid bit, so no result comes out of reset.
//   the receiver takes every result; there is no stall path.
// ----------------------------------------------------------------------------
module vector3_length_normalize_distance
  import vln_pkg::*;
#(
  parameter int unsigned UNIT_FRAC_BITS = UnitFracBitsD
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    func_i,
  input  logic signed [VecW-1:0]  a_x_i,
  input  logic signed [VecW-1:0]  a_y_i,
  input  logic signed [VecW-1:0]  a_z_i,
  input  logic signed [VecW-1:0]  b_x_i,
  input  logic signed [VecW-1:0]  b_y_i,
  input  logic signed [VecW-1:0]  b_z_i,
  output logic                    done_o,
  output logic [MagW-1:0]         magnitude_o,
  output logic signed [VecW-1:0]  unit_x_o,
  output logic signed [VecW-1:0]  unit_y_o,
  output logic signed [VecW-1:0]  unit_z_o,
  output logic                    nonzero_o
);

  localparam int unsigned DivSteps = UNIT_FRAC_BITS + 1;

  typedef struct packed {
    logic            func;
    logic [2:0]      neg;
    logic [VecW-1:0] ax;
    logic [VecW-1:0] ay;
    logic [VecW-1:0] az;
  } side_t;

  assign busy_o = 1'b0;

  // stage 1: differences a-b, or a itself for func_i 0
  logic                   v1_q;
  logic signed [DiffW-1:0] d1_q [3];
  logic signed [VecW-1:0]  a1_q [3];
  logic                   f1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q    <= func_i;
    a1_q[0] <= a_x_i;
    a1_q[1] <= a_y_i;
    a1_q[2] <= a_z_i;
    d1_q[0] <= func_i ? DiffW'(a_x_i) - DiffW'(b_x_i) : DiffW'(a_x_i);
    d1_q[1] <= func_i ? DiffW'(a_y_i) - DiffW'(b_y_i) : DiffW'(a_y_i);
    d1_q[2] <= func_i ? DiffW'(a_z_i) - DiffW'(b_z_i) : DiffW'(a_z_i);
  end

  // stage 2: squares
  logic           v2_q;
  logic [SqW-1:0] sq2_q [3];
  side_t          s2_q;
  logic [MagW-1:0] dm [3];
  logic [VecW-1:0] am [3];

  for (genvar i = 0; i < 3; i++) begin : g_abs
    assign dm[i] = d1_q[i][DiffW-1] ? MagW'(-d1_q[i]) : MagW'(d1_q[i]);
    assign am[i] = a1_q[i][VecW-1] ? VecW'(-a1_q[i]) : VecW'(a1_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= SqW'(dm[i]) * SqW'(dm[i]);
    end
    s2_q <= '{func: f1_q, neg: {a1_q[2][VecW-1], a1_q[1][VecW-1], a1_q[0][VecW-1]},
              ax: am[0], ay: am[1], az: am[2]};
  end

  // root pipeline, stage 0 holds the sum of squares
  logic            rv_q   [SqrtSteps+1];
  logic            rnz_q  [SqrtSteps+1];
  logic [SumW-1:0] rrem_q [SqrtSteps+1];
  logic [MagW-1:0] rrt_q  [SqrtSteps+1];
  side_t           rs_q   [SqrtSteps+1];
  logic [SumW-1:0] sum_d;

  assign sum_d = SumW'(sq2_q[0]) + SumW'(sq2_q[1]) + SumW'(sq2_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else begin
      rv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rrem_q[0] <= sum_d;
    rnz_q[0]  <= sum_d != '0;
    rrt_q[0]  <= '0;
    rs_q[0]   <= s2_q;
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_root
    localparam int unsigned Bit = SqrtSteps - 1 - s;
    logic [SumW-1:0] trial;
    logic            take;
    assign trial = (SumW'(rrt_q[s]) << (Bit + 1)) | (SumW'(1) << (2 * Bit));
    assign take  = rrem_q[s] >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[s+1] <= 1'b0;
      end else begin
        rv_q[s+1] <= rv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rrem_q[s+1] <= take ? rrem_q[s] - trial : rrem_q[s];
      rrt_q[s+1]  <= take ? (rrt_q[s] | (MagW'(1) << Bit)) : rrt_q[s];
      rnz_q[s+1]  <= rnz_q[s];
      rs_q[s+1]   <= rs_q[s];
    end
  end

  // divider lanes with side data delayed alongside
  logic [UNIT_FRAC_BITS:0] quo [3];
  logic            qv_q  [DivSteps+1];
  logic            qnz_q [DivSteps+1];
  logic            qf_q  [DivSteps+1];
  logic [2:0]      qn_q  [DivSteps+1];
  logic [MagW-1:0] ql_q  [DivSteps+1];

  vln_div #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_div_x (
    .clk_i, .mag_i(rs_q[SqrtSteps].ax), .len_i(rrt_q[SqrtSteps]), .quo_o(quo[0]));
  vln_div #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_div_y (
    .clk_i, .mag_i(rs_q[SqrtSteps].ay), .len_i(rrt_q[SqrtSteps]), .quo_o(quo[1]));
  vln_div #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_div_z (
    .clk_i, .mag_i(rs_q[SqrtSteps].az), .len_i(rrt_q[SqrtSteps]), .quo_o(quo[2]));

  assign qv_q[0]  = rv_q[SqrtSteps];
  assign qnz_q[0] = rnz_q[SqrtSteps];
  assign qf_q[0]  = rs_q[SqrtSteps].func;
  assign qn_q[0]  = rs_q[SqrtSteps].neg;
  assign ql_q[0]  = rrt_q[SqrtSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[k+1] <= 1'b0;
      end else begin
        qv_q[k+1] <= qv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      qnz_q[k+1] <= qnz_q[k];
      qf_q[k+1]  <= qf_q[k];
      qn_q[k+1]  <= qn_q[k];
      ql_q[k+1]  <= ql_q[k];
    end
  end

  // output register
  logic            keep;
  logic [VecW-1:0] unit_d [3];

  assign keep = qnz_q[DivSteps] && !qf_q[DivSteps];

  for (genvar i = 0; i < 3; i++) begin : g_unit
    logic [VecW-1:0] q32;
    assign q32       = VecW'(quo[i]);
    assign unit_d[i] = !keep ? '0 : (qn_q[DivSteps][i] ? VecW'(-q32) : q32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= qv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    magnitude_o <= ql_q[DivSteps];
    unit_x_o    <= unit_d[0];
    unit_y_o    <= unit_d[1];
    unit_z_o    <= unit_d[2];
    nonzero_o   <= qnz_q[DivSteps];
  end

endmodule

[rtl/vln_checker.sv]
// ----------------------------------------------------------------------------
// vln_assert
// port-level checks for vector3_length_normalize_distance
// ----------------------------------------------------------------------------
module vln_assert
  import vln_pkg::*;
#(
  parameter int unsigned UNIT_FRAC_BITS = UnitFracBitsD
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [MagW-1:0]        magnitude_o,
  input logic signed [VecW-1:0] unit_x_o,
  input logic signed [VecW-1:0] unit_y_o,
  input logic signed [VecW-1:0] unit_z_o,
  input logic                   nonzero_o
);

  localparam int unsigned Lat = 38 + UNIT_FRAC_BITS;

  a_word_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o)
    else $error("taken word gave no result at fixed latency");

  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result with no word taken at fixed latency");

  a_zero_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !nonzero_o |-> magnitude_o == '0 && unit_x_o == '0 &&
      unit_y_o == '0 && unit_z_o == '0)
    else $error("zero vector gave nonzero fields");

  a_mag_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && nonzero_o |-> magnitude_o != '0)
    else $error("nonzero vector with zero length");

endmodule

bind vector3_length_normalize_distance vln_assert #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .magnitude_o,
  .unit_x_o, .unit_y_o, .unit_z_o, .nonzero_o);
